/* hdl/fsmp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the flash file table mapping parser.
// No dependencies; imported by every module of the block.
package fsmp_pkg;

  localparam logic [31:0] ID_V1       = 32'h1234_5678;
  localparam logic [31:0] ID_V2       = 32'h1234_5679;
  localparam logic [31:0] SECTOR_STEP = 32'h0001_0000;
  localparam logic [16:0] SKIP_FIXED  = 17'd12;   // size and timestamp bytes after the name

  typedef enum logic [3:0] {
    PH_WAIT     = 4'd0,
    PH_ID       = 4'd1,
    PH_COUNT    = 4'd2,
    PH_FLAGS    = 4'd3,
    PH_VADDR    = 4'd4,
    PH_SCOUNT   = 4'd5,
    PH_SECTOR   = 4'd6,
    PH_NAMELEN  = 4'd7,
    PH_SKIPNAME = 4'd8,
    PH_COMMLEN  = 4'd9,
    PH_SKIPCOMM = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MAP    = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_BAD_ID = 2'd2,
    KIND_V2     = 2'd3
  } kind_t;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] addr;
    logic [15:0] sector;
    logic        final_item;
  } result_t;

endpackage

/* hdl/fsmp_in_reg.sv */
`timescale 1ns / 1ps
// Input register of the parser: holds one table byte until the parser takes it.
// Depends on fsmp_pkg.
module fsmp_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // table_byte[7:0]
  input  logic             s_tuser,   // first_byte
  input  logic             advance,
  output logic             in_valid,
  output fsmp_pkg::in_word_t in_word
);
  import fsmp_pkg::*;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word.first <= s_tuser;
      in_word.data  <= s_tdata;
    end
  end

endmodule

/* hdl/fsmp_parser.sv */
`timescale 1ns / 1ps
// Byte-wide field parser: phase, field counters and file state, one byte per step.
// Depends on fsmp_pkg.
module fsmp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  fsmp_pkg::in_word_t word,
  input  logic               ignore_obsolete,
  output fsmp_pkg::result_t  res
);
  import fsmp_pkg::*;

  phase_t      phase, phase_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [31:0] acc, acc_next;
  logic [15:0] files_left, files_left_next;
  logic [15:0] sectors_left, sectors_left_next;
  logic [31:0] cur_addr, cur_addr_next;
  logic        obsolete, obsolete_next;

  phase_t      ph;
  logic [16:0] bl;
  logic [16:0] bl_dec;
  logic [31:0] acc_in;
  logic [31:0] val;
  logic [15:0] files_dec;
  logic [15:0] sectors_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      bytes_left   <= '0;
      acc          <= '0;
      files_left   <= '0;
      sectors_left <= '0;
      cur_addr     <= '0;
      obsolete     <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      acc          <= acc_next;
      files_left   <= files_left_next;
      sectors_left <= sectors_left_next;
      cur_addr     <= cur_addr_next;
      obsolete     <= obsolete_next;
    end
  end

  always_comb begin
    // first byte restarts at the identifier
    ph     = word.first ? PH_ID : phase;
    bl     = word.first ? 17'd4 : bytes_left;
    acc_in = word.first ? 32'd0 : acc;
    bl_dec = (bl != 17'd0) ? bl - 17'd1 : bl;
    val    = {acc_in[23:0], word.data};
    files_dec   = files_left - 16'd1;
    sectors_dec = sectors_left - 16'd1;

    phase_next        = ph;
    bytes_left_next   = bl;
    acc_next          = acc_in;
    files_left_next   = files_left;
    sectors_left_next = sectors_left;
    cur_addr_next     = cur_addr;
    obsolete_next     = obsolete;

    res            = '0;
    res.kind       = KIND_MAP;

    unique case (ph)
      PH_WAIT: begin
      end
      PH_SKIPNAME, PH_SKIPCOMM: begin
        bytes_left_next = bl_dec;
        if (bl_dec == 17'd0) begin
          acc_next = '0;
          if (ph == PH_SKIPNAME) begin
            phase_next      = PH_COMMLEN;
            bytes_left_next = 17'd2;
          end else begin
            files_left_next = files_dec;
            if (files_dec == 16'd0) begin
              phase_next     = PH_WAIT;
              res.valid      = 1'b1;
              res.kind       = KIND_DONE;
              res.final_item = 1'b1;
            end else begin
              phase_next      = PH_FLAGS;
              bytes_left_next = 17'd2;
            end
          end
        end
      end
      default: begin
        acc_next        = val;
        bytes_left_next = bl_dec;
        if (bl_dec == 17'd0) begin
          // field complete: start the next one unless noted
          acc_next        = '0;
          bytes_left_next = 17'd2;
          unique case (ph)
            PH_ID: begin
              if (val == ID_V1) begin
                phase_next = PH_COUNT;
              end else begin
                phase_next      = PH_WAIT;
                bytes_left_next = bl_dec;
                acc_next        = val;
                res.valid       = 1'b1;
                res.kind        = (val == ID_V2) ? KIND_V2 : KIND_BAD_ID;
                res.final_item  = 1'b1;
              end
            end
            PH_COUNT: begin
              files_left_next = val[15:0];
              if (val[15:0] == 16'd0) begin
                phase_next      = PH_WAIT;
                bytes_left_next = bl_dec;
                acc_next        = val;
                res.valid       = 1'b1;
                res.kind        = KIND_DONE;
                res.final_item  = 1'b1;
              end else begin
                phase_next = PH_FLAGS;
              end
            end
            PH_FLAGS: begin
              obsolete_next   = val[0];
              phase_next      = PH_VADDR;
              bytes_left_next = 17'd4;
            end
            PH_VADDR: begin
              cur_addr_next = val;
              phase_next    = PH_SCOUNT;
            end
            PH_SCOUNT: begin
              sectors_left_next = val[15:0];
              phase_next = (val[15:0] == 16'd0) ? PH_NAMELEN : PH_SECTOR;
            end
            PH_SECTOR: begin
              if (cur_addr != 32'd0 && !(obsolete && ignore_obsolete)) begin
                res.valid     = 1'b1;
                res.kind      = KIND_MAP;
                res.addr      = cur_addr;
                res.sector    = val[15:0];
                cur_addr_next = cur_addr + SECTOR_STEP;
              end
              sectors_left_next = sectors_dec;
              phase_next = (sectors_dec == 16'd0) ? PH_NAMELEN : PH_SECTOR;
            end
            PH_NAMELEN: begin
              phase_next      = PH_SKIPNAME;
              bytes_left_next = {1'b0, val[15:0]} + SKIP_FIXED;
            end
            PH_COMMLEN: begin
              if (val[15:0] == 16'd0) begin
                files_left_next = files_dec;
                if (files_dec == 16'd0) begin
                  phase_next      = PH_WAIT;
                  bytes_left_next = bl_dec;
                  acc_next        = val;
                  res.valid       = 1'b1;
                  res.kind        = KIND_DONE;
                  res.final_item  = 1'b1;
                end else begin
                  phase_next = PH_FLAGS;
                end
              end else begin
                phase_next      = PH_SKIPCOMM;
                bytes_left_next = {1'b0, val[15:0]};
              end
            end
            default: begin
              phase_next      = PH_WAIT;
              bytes_left_next = bl_dec;
              acc_next        = val;
            end
          endcase
        end
      end
    endcase
  end

endmodule

/* hdl/fsmp_out_reg.sv */
`timescale 1ns / 1ps
// Result register: holds one result word until the receiver takes it.
// Depends on fsmp_pkg.
module fsmp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fsmp_pkg::result_t res_in,
  output logic              out_free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // mapped_address[31:0], sector_index[47:32]
  output logic [1:0]        m_tuser,   // kind[1:0]
  output logic              m_tlast    // final_item
);
  import fsmp_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      m_tdata <= {res_in.sector, res_in.addr};
      m_tuser <= res_in.kind;
      m_tlast <= res_in.final_item;
    end
  end

endmodule

/* hdl/fat_sector_mapping_parser.sv */
`timescale 1ns / 1ps
// Flash file table mapping parser, top level.
// Depends on fsmp_pkg, fsmp_in_reg, fsmp_parser and fsmp_out_reg.
//
// Feed the file allocation table one byte per word on the slave stream:
// s_tdata carries the byte, s_tuser marks the first identifier byte and
// restarts parsing. Each mapping leaves on the master stream as one word with
// m_tuser = mapping, the virtual address in m_tdata[31:0] and the sector
// number in m_tdata[47:32]. Done, bad identifier and version-two results carry
// zero data and m_tlast high. Bytes that cause no result produce no word.
//
// Throughput is one byte per cycle while the result register is free: a byte sits in the
// input register while the parser logic updates its field state and loads the result
// register. A stalled result register holds the byte in the input register.
// When the receiver stalls, the result register holds its word and the input
// register holds one more byte; s_tready then drops until the result is taken.
// The cfg channel (cfg_data = ignore_obsolete) is always ready; write it only
// while the block is idle. Reset empties both registers, returns the parser to
// waiting for a first byte and sets ignore_obsolete to 1.
module fat_sector_mapping_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // table_byte[7:0]
  input  logic        s_tuser,   // first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // mapped_address[31:0], sector_index[47:32]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,   // final_item
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // ignore_obsolete
);
  import fsmp_pkg::*;

  logic     ignore_obsolete;
  logic     in_valid;
  in_word_t in_word;
  logic     out_free;
  logic     advance;
  result_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_obsolete <= 1'b1;
    end else if (cfg_valid) begin
      ignore_obsolete <= cfg_data;
    end
  end

  assign advance = in_valid && out_free;

  fsmp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .in_word  (in_word)
  );

  fsmp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .word            (in_word),
    .ignore_obsolete (ignore_obsolete),
    .res             (res)
  );

  fsmp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res.valid),
    .res_in   (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !advance)
    else $error("result register overwritten while stalled");

  // a held byte blocks new input
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> !s_tready)
    else $error("input accepted while byte held");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != KIND_MAP)))
    else $error("final flag does not match result kind");

  a_map_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_MAP) |-> (m_tdata[31:0] != 32'd0))
    else $error("mapping emitted with zero address");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_MAP) |-> (m_tdata == 48'd0))
    else $error("status word carries nonzero data");

endmodule

/* bench/fat_sector_mapping_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for fat_sector_mapping_parser: streams directed and random file
// tables through the byte stream, tracks the table parse in parallel and checks every
// mapping, done and identifier word. Depends on fsmp_pkg and the block's RTL.
module fat_sector_mapping_parser_test;
  import fsmp_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int RANDOM_BYTES = 1040;
  localparam int SETTLE       = 8;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } table_byte_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] addr;
    logic [15:0] sector;
    logic        fin;
  } map_word_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  table_byte_t table_bytes[$];
  map_word_t   expected_maps[$];
  int          errors    = 0;
  int          cycles    = 0;
  int          queued    = 0;
  int          sent      = 0;
  int          cut_left  = -1;
  bit          gaps_on   = 1'b1;

  // shadow parse state
  phase_t      ph        = PH_WAIT;
  logic [16:0] left      = '0;
  logic [31:0] acc       = '0;
  logic [15:0] files     = '0;
  logic [15:0] secs      = '0;
  logic [31:0] vaddr     = '0;
  logic        obs       = 1'b0;
  logic        ign       = 1'b1;

  fat_sector_mapping_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void post_map(input kind_t k, input logic [31:0] a,
                                   input logic [15:0] s, input logic f);
    map_word_t w;
    w.kind = k;
    w.addr = a;
    w.sector = s;
    w.fin = f;
    expected_maps.push_back(w);
  endfunction

  function automatic void open_field(input phase_t p, input logic [16:0] n);
    ph = p;
    left = n;
    acc = '0;
  endfunction

  function automatic void close_record();
    files = files - 16'd1;
    if (files == 16'd0) begin
      ph = PH_WAIT;
      post_map(KIND_DONE, 32'd0, 16'd0, 1'b1);
    end else begin
      open_field(PH_FLAGS, 17'd2);
    end
  endfunction

  function automatic void parse_table_byte(input logic [7:0] b, input logic first);
    logic [31:0] v;
    if (first) open_field(PH_ID, 17'd4);
    if (ph == PH_WAIT) return;
    // name and comment bodies are counted, not assembled
    if (ph == PH_SKIPNAME || ph == PH_SKIPCOMM) begin
      if (left != 17'd0) left = left - 17'd1;
      if (left != 17'd0) return;
      if (ph == PH_SKIPNAME) open_field(PH_COMMLEN, 17'd2);
      else close_record();
      return;
    end
    acc = {acc[23:0], b};
    if (left != 17'd0) left = left - 17'd1;
    if (left != 17'd0) return;
    v = acc;
    case (ph)
      PH_ID: begin
        if (v == ID_V1) begin
          open_field(PH_COUNT, 17'd2);
        end else begin
          ph = PH_WAIT;
          post_map((v == ID_V2) ? KIND_V2 : KIND_BAD_ID, 32'd0, 16'd0, 1'b1);
        end
      end
      PH_COUNT: begin
        files = v[15:0];
        if (files == 16'd0) begin
          ph = PH_WAIT;
          post_map(KIND_DONE, 32'd0, 16'd0, 1'b1);
        end else begin
          open_field(PH_FLAGS, 17'd2);
        end
      end
      PH_FLAGS: begin
        obs = v[0];
        open_field(PH_VADDR, 17'd4);
      end
      PH_VADDR: begin
        vaddr = v;
        open_field(PH_SCOUNT, 17'd2);
      end
      PH_SCOUNT: begin
        secs = v[15:0];
        open_field((secs == 16'd0) ? PH_NAMELEN : PH_SECTOR, 17'd2);
      end
      PH_SECTOR: begin
        if (vaddr != 32'd0 && !(obs && ign)) begin
          post_map(KIND_MAP, vaddr, v[15:0], 1'b0);
          vaddr = vaddr + SECTOR_STEP;
        end
        secs = secs - 16'd1;
        open_field((secs == 16'd0) ? PH_NAMELEN : PH_SECTOR, 17'd2);
      end
      PH_NAMELEN: open_field(PH_SKIPNAME, {1'b0, v[15:0]} + SKIP_FIXED);
      PH_COMMLEN: begin
        if (v[15:0] == 16'd0) close_record();
        else open_field(PH_SKIPCOMM, {1'b0, v[15:0]});
      end
      default: ph = PH_WAIT;
    endcase
  endfunction

  // byte driver: advance on handshake, idle at random
  always @(posedge clk) begin
    table_byte_t nxt;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_table_byte(s_tdata, s_tuser);
        sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (table_bytes.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 15)) begin
          nxt = table_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tuser  <= nxt.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    map_word_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_maps.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: kind %0d addr %h sector %h last %b",
                     m_tuser, m_tdata[31:0], m_tdata[47:32], m_tlast);
        end else begin
          want = expected_maps.pop_front();
          if (m_tuser != want.kind || m_tdata[31:0] != want.addr ||
              m_tdata[47:32] != want.sector || m_tlast != want.fin) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected kind %0d addr %h sector %h last %b",
                       want.kind, want.addr, want.sector, want.fin);
              $display("          got      kind %0d addr %h sector %h last %b",
                       m_tuser, m_tdata[31:0], m_tdata[47:32], m_tlast);
            end
          end
        end
      end
      m_tready <= !(gaps_on && $urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("[fat_sector_mapping_parser] ERROR");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic first);
    table_byte_t w;
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    w.data = b;
    w.first = first;
    table_bytes.push_back(w);
    queued++;
  endtask

  // big-endian, n bytes
  task automatic put_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) put_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic put_id(input logic [31:0] id);
    put_byte(id[31:24], 1'b1);
    put_field(id, 3);
  endtask

  task automatic put_tail(input int name_len, input int comm_len);
    put_field(name_len, 2);
    repeat (name_len + 12) put_byte(8'($urandom), 1'b0);
    put_field(comm_len, 2);
    repeat (comm_len) put_byte(8'($urandom), 1'b0);
  endtask

  task automatic put_record(input logic [15:0] flags, input logic [31:0] addr,
                            input int nsec, input int name_len, input int comm_len);
    put_field({16'd0, flags}, 2);
    put_field(addr, 4);
    put_field(nsec, 2);
    repeat (nsec) put_field($urandom, 2);
    put_tail(name_len, comm_len);
  endtask

  function automatic logic [31:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'd0;
    if (sel == 1)
      return {12'hFFF, 4'($urandom_range(0, 15)), 16'h0000} | ($urandom & 32'hFFFF);
    return $urandom;
  endfunction

  // well-formed table, optionally cut short after a number of bytes
  task automatic put_random_table(input int cut);
    int nf;
    cut_left = cut;
    nf = $urandom_range(1, 4);
    put_id(ID_V1);
    put_field(nf, 2);
    repeat (nf)
      put_record(16'($urandom), pick_addr(), $urandom_range(0, 6), $urandom_range(0, 5),
                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5));
    cut_left = -1;
  endtask

  // hold until every byte is taken and every word has come back
  task automatic drain();
    do @(posedge clk); while (sent != queued || expected_maps.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_ignore(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ign = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int start;
    int sel;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_ignore(1'b1);

    // stray bytes before any start, then a bad identifier, a version-two identifier and an empty table
    put_byte(8'hA5, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_id(32'hDEAD_BEEF);
    put_id(ID_V2);
    put_id(ID_V1);
    put_field(0, 2);
    // three files: edge sector numbers, obsolete file, address wrapping to zero
    put_id(ID_V1);
    put_field(3, 2);
    put_field(32'h0000, 2);
    put_field(32'h0010_0000, 4);
    put_field(2, 2);
    put_field(32'h0000, 2);
    put_field(32'hFFFF, 2);
    put_tail(0, 0);
    put_record(16'h0001, 32'h2000_0000, 2, 3, 2);
    put_record(16'h0000, 32'hFFFE_0000, 4, 1, 0);
    // trailing bytes after done
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    // zero address and zero sector count
    put_id(ID_V1);
    put_field(2, 2);
    put_record(16'h0000, 32'h0000_0000, 2, 0, 1);
    put_record(16'h0000, 32'h8000_0000, 0, 2, 0);
    // restart inside the identifier, then inside a record
    put_byte(8'h12, 1'b1);
    put_byte(8'h34, 1'b0);
    put_id(ID_V1);
    put_field(2, 2);
    put_field(32'h0000, 2);
    put_field(32'h1234, 2);
    drain();

    set_ignore(1'b0);
    put_id(ID_V1);
    put_field(1, 2);
    put_record(16'h0001, 32'h4000_0000, 3, 0, 0);
    // largest count and name length, cut short inside the name;
    // abandoned by the next start
    put_id(ID_V1);
    put_field(32'hFFFF, 2);
    cut_left = 40;
    put_record(16'hFFFF, 32'hFFFF_FFFF, 2, 65535, 65535);
    cut_left = -1;
    drain();

    for (int r = 0; r < 4; r++) begin
      set_ignore(r[0]);
      gaps_on = (r != 2);
      start = queued;
      while (queued - start < RANDOM_BYTES / 4) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          put_random_table(-1);
        end else if (sel == 7) begin
          put_random_table($urandom_range(1, 30));
        end else if (sel == 8) begin
          repeat ($urandom_range(1, 8)) put_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          put_id(($urandom_range(0, 1) == 0) ? ID_V2 : $urandom);
        end
      end
      drain();
    end
    gaps_on = 1'b1;

    if (errors == 0 && expected_maps.size() == 0) begin
      $display("[fat_sector_mapping_parser] OK");
    end else begin
      $display("[fat_sector_mapping_parser] ERROR");
    end
    $finish;
  end

endmodule
